@@ design/gbba_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbba_pkg
// Shared sizes, codes and state type of the grouped bitmap block allocator.
// ----------------------------------------------------------------------------
package gbba_pkg;

    // bitmap geometry
    localparam int GROUP_BLOCKS = 1024;
    localparam int MAX_GROUPS   = 8;
    localparam int MAP_BITS     = MAX_GROUPS * GROUP_BLOCKS;
    localparam int MAP_WORDS    = (MAP_BITS + 31) / 32;
    localparam int WORD_AW      = $clog2(MAP_WORDS);
    localparam int BIT_W        = $clog2(MAP_BITS);
    localparam int WPG          = GROUP_BLOCKS / 32;
    localparam int GB_W         = $clog2(GROUP_BLOCKS);

    // configuration port
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_GROUP_COUNT    = 2'd0;
    localparam logic [1:0] REG_TOTAL_BLOCKS   = 2'd1;
    localparam logic [1:0] REG_FIRST_DATA_BIT = 2'd2;

    // request codes
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    // status codes
    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_BAD     = 3'd1;
    localparam logic [2:0] STS_META    = 3'd2;
    localparam logic [2:0] STS_FREE    = 3'd3;
    localparam logic [2:0] STS_NOSPACE = 3'd4;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SCAN,
        S_FRD,
        S_FPROC,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

@@ design/gbba_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbba_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface gbba_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] block_number;
    logic [15:0] block_count;
    logic [7:0]  word_index;
    logic [31:0] map_word;

    modport source (output valid, req_type, block_number, block_count, word_index,
                    map_word, input ready);
    modport sink (input valid, req_type, block_number, block_count, word_index,
                  map_word, output ready);
endinterface
`default_nettype wire

@@ design/gbba_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbba_rsp_if
// Response channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface gbba_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [12:0] result_block;
    logic [10:0] blocks_cleared;

    modport source (output valid, status, result_block, blocks_cleared, input ready);
    modport sink (input valid, status, result_block, blocks_cleared, output ready);
endinterface
`default_nettype wire

@@ design/gbba_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gbba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ design/grouped_bitmap_block_allocator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// grouped_bitmap_block_allocator
// First-fit block allocator over a grouped free-block bitmap held in RAM.
// ----------------------------------------------------------------------------
// Usage: requests enter on req (valid/ready), one result per request leaves
// on rsp (valid/ready). Registers group_count, total_blocks, first_data_bit
// sit on the APB port at byte addresses 0, 4 and 8; write them only while
// the block is idle.
// Timing: one request is worked on at a time; ready is high only when idle.
// A load writes its word when accepted. An allocate streams bitmap words
// out of the RAM one per cycle, pausing where it skips a group, until a
// usable free bit is found or all groups are scanned. A free reads each
// word it touches (FRD) and rewrites it (FPROC) before reading the next.
// Both share the single RAM read port.
// Reset: the bitmap RAM is cleared by a pass over all 256 words, one word
// per cycle, during which no request is taken; APB writes are taken as usual.
// Stall: a finished result waits in the output register; the next request
// is taken meanwhile, and its result waits in the core until the output
// register frees.
// ----------------------------------------------------------------------------
module grouped_bitmap_block_allocator (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    gbba_req_if.sink                          req,
    gbba_rsp_if.source                        rsp,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [gbba_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    localparam int AW = gbba_pkg::WORD_AW;

    gbba_pkg::state_t state_reg, state_next;

    logic [3:0]  group_count_reg;
    logic [13:0] total_blocks_reg;
    logic [9:0]  first_data_bit_reg;

    logic [AW-1:0] clr_reg, clr_next;
    logic [AW:0]   iss_reg, iss_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;

    logic [AW-1:0] f_wadr_reg, f_wadr_next;
    logic [4:0]    f_lo_reg, f_lo_next;
    logic [AW-1:0] f_lastw_reg, f_lastw_next;
    logic [5:0]    f_hilast_reg, f_hilast_next;

    logic [2:0]  res_status_reg, res_status_next;
    logic [12:0] res_block_reg, res_block_next;
    logic [10:0] res_cleared_reg, res_cleared_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_status_reg, out_status_next;
    logic [12:0] out_block_reg, out_block_next;
    logic [10:0] out_cleared_reg, out_cleared_next;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0]   wr_data, rd_data;

    logic in_fire, out_free;

    // ram
    gbba_ram #(.WIDTH(32), .DEPTH(gbba_pkg::MAP_WORDS)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // apb registers
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg    <= 4'd1;
            total_blocks_reg   <= 14'd8192;
            first_data_bit_reg <= 10'd8;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                gbba_pkg::REG_GROUP_COUNT:    group_count_reg    <= pwdata[3:0];
                gbba_pkg::REG_TOTAL_BLOCKS:   total_blocks_reg   <= pwdata[13:0];
                gbba_pkg::REG_FIRST_DATA_BIT: first_data_bit_reg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            gbba_pkg::REG_GROUP_COUNT:    prdata = {28'd0, group_count_reg};
            gbba_pkg::REG_TOTAL_BLOCKS:   prdata = {18'd0, total_blocks_reg};
            gbba_pkg::REG_FIRST_DATA_BIT: prdata = {22'd0, first_data_bit_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    // groups in use and scan limit in words
    logic [3:0]  n_groups;
    logic [AW:0] scan_limit;

    assign n_groups   = (group_count_reg > 4'(gbba_pkg::MAX_GROUPS)) ?
                        4'(gbba_pkg::MAX_GROUPS) : group_count_reg;
    assign scan_limit = (AW+1)'(n_groups) * (AW+1)'(gbba_pkg::WPG);

    // allocate scan: examine the word returned for the pending read
    logic [4:0]                  zpos;
    logic                        zero_found, meta_hit, over_total;
    logic                        alloc_ok, alloc_skip, scan_end, can_issue;
    logic [gbba_pkg::GB_W-1:0]   zbit_grp;
    logic [gbba_pkg::BIT_W-1:0]  zgbit;
    logic [AW:0]                 pend_grp, skip_iss;

    always_comb
    begin
        zpos = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!rd_data[i])
            begin
                zpos = 5'(i);
            end
        end
    end

    assign pend_grp   = (AW+1)'({1'b0, pend_addr_reg} / gbba_pkg::WPG);
    assign zbit_grp   = gbba_pkg::GB_W'((pend_addr_reg % gbba_pkg::WPG) * 32 + zpos);
    assign zgbit      = {pend_addr_reg, zpos};
    assign zero_found = pend_reg && (rd_data != 32'hffff_ffff);
    assign meta_hit   = (zbit_grp == '0) ||
                        ((pend_grp == '0) &&
                         ({{(16-gbba_pkg::GB_W){1'b0}}, zbit_grp} <
                          {6'd0, first_data_bit_reg}));
    assign over_total = {{(16-gbba_pkg::BIT_W){1'b0}}, zgbit} >= {2'b00, total_blocks_reg};
    assign alloc_ok   = zero_found && !meta_hit && !over_total;
    assign alloc_skip = zero_found && (meta_hit || over_total);
    assign scan_end   = !pend_reg && (iss_reg >= scan_limit);
    assign can_issue  = !zero_found && (iss_reg < scan_limit);
    assign skip_iss   = (AW+1)'((pend_grp + 1'b1) * gbba_pkg::WPG);

    // free request checks at accept
    logic [15:0] f_grp;
    logic [16:0] f_end, f_end_m1;
    logic [17:0] f_grp_end;
    logic        f_bad;

    assign f_grp     = 16'(req.block_number / gbba_pkg::GROUP_BLOCKS);
    assign f_end     = {1'b0, req.block_number} + {1'b0, req.block_count};
    assign f_end_m1  = f_end - 17'd1;
    assign f_grp_end = 18'((f_grp + 17'd1) * gbba_pkg::GROUP_BLOCKS);
    assign f_bad     = (f_grp >= {12'd0, n_groups}) ||
                       (f_end > {3'd0, total_blocks_reg}) ||
                       ({1'b0, f_end} > f_grp_end);

    // free word processing
    logic [5:0]  f_hi, f_stop;
    logic [31:0] f_range, f_meta, f_badm, f_clr;
    logic [4:0]  f_badpos;
    logic        f_anybad, f_last;
    logic [gbba_pkg::GB_W-1:0] f_bg;

    assign f_last   = (f_wadr_reg == f_lastw_reg);
    assign f_hi     = f_last ? f_hilast_reg : 6'd32;
    assign f_badm   = f_range & (f_meta | ~rd_data);
    assign f_anybad = (f_badm != 32'd0);
    assign f_stop   = f_anybad ? {1'b0, f_badpos} : f_hi;

    always_comb
    begin
        f_bg     = '0;
        f_range  = '0;
        f_meta   = '0;
        f_clr    = '0;
        f_badpos = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            f_bg       = gbba_pkg::GB_W'((f_wadr_reg % gbba_pkg::WPG) * 32 + i);
            f_range[i] = (6'(i) >= {1'b0, f_lo_reg}) && (6'(i) < f_hi);
            f_meta[i]  = (f_bg == '0) ||
                         ((f_wadr_reg / gbba_pkg::WPG == 0) &&
                          ({{(16-gbba_pkg::GB_W){1'b0}}, f_bg} <
                           {6'd0, first_data_bit_reg}));
        end
        for (int i = 31; i >= 0; i--)
        begin
            if (f_badm[i])
            begin
                f_badpos = 5'(i);
            end
        end
        for (int i = 0; i < 32; i++)
        begin
            f_clr[i] = (6'(i) >= {1'b0, f_lo_reg}) && (6'(i) < f_stop);
        end
    end

    assign in_fire  = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gbba_pkg::S_CLR:
            begin
                if (clr_reg == AW'(gbba_pkg::MAP_WORDS - 1))
                begin
                    state_next = gbba_pkg::S_IDLE;
                end
            end
            gbba_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    case (req.req_type)
                        gbba_pkg::REQ_ALLOC: state_next = gbba_pkg::S_SCAN;
                        gbba_pkg::REQ_FREE:
                        begin
                            if (f_bad || req.block_count == 16'd0)
                            begin
                                state_next = gbba_pkg::S_DONE;
                            end
                            else
                            begin
                                state_next = gbba_pkg::S_FRD;
                            end
                        end
                        default: state_next = gbba_pkg::S_DONE;
                    endcase
                end
            end
            gbba_pkg::S_SCAN:
            begin
                if (alloc_ok || scan_end)
                begin
                    state_next = gbba_pkg::S_DONE;
                end
            end
            gbba_pkg::S_FRD:   state_next = gbba_pkg::S_FPROC;
            gbba_pkg::S_FPROC:
            begin
                if (f_anybad || f_last)
                begin
                    state_next = gbba_pkg::S_DONE;
                end
                else
                begin
                    state_next = gbba_pkg::S_FRD;
                end
            end
            gbba_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = gbba_pkg::S_IDLE;
                end
            end
            default: state_next = gbba_pkg::S_IDLE;
        endcase
    end

    // datapath, memory control and outputs
    assign req.ready = (state_reg == gbba_pkg::S_IDLE);

    always_comb
    begin
        clr_next         = clr_reg;
        iss_next         = iss_reg;
        pend_next        = pend_reg;
        pend_addr_next   = pend_addr_reg;
        f_wadr_next      = f_wadr_reg;
        f_lo_next        = f_lo_reg;
        f_lastw_next     = f_lastw_reg;
        f_hilast_next    = f_hilast_reg;
        res_status_next  = res_status_reg;
        res_block_next   = res_block_reg;
        res_cleared_next = res_cleared_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_block_next   = out_block_reg;
        out_cleared_next = out_cleared_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = '0;
        rd_en            = 1'b0;
        rd_addr          = '0;
        case (state_reg)
            gbba_pkg::S_CLR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            gbba_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    res_status_next  = gbba_pkg::STS_BAD;
                    res_block_next   = '0;
                    res_cleared_next = '0;
                    iss_next         = '0;
                    pend_next        = 1'b0;
                    f_wadr_next      = req.block_number[gbba_pkg::BIT_W-1:5];
                    f_lo_next        = req.block_number[4:0];
                    f_lastw_next     = f_end_m1[gbba_pkg::BIT_W-1:5];
                    f_hilast_next    = {1'b0, f_end_m1[4:0]} + 6'd1;
                    case (req.req_type)
                        gbba_pkg::REQ_FREE:
                        begin
                            if (!f_bad)
                            begin
                                res_status_next = gbba_pkg::STS_OK;
                            end
                        end
                        gbba_pkg::REQ_LOAD:
                        begin
                            if ({1'b0, req.word_index} < 9'(gbba_pkg::MAP_WORDS))
                            begin
                                wr_en           = 1'b1;
                                wr_addr         = AW'(req.word_index);
                                wr_data         = req.map_word;
                                res_status_next = gbba_pkg::STS_OK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            gbba_pkg::S_SCAN:
            begin
                if (alloc_ok)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = pend_addr_reg;
                    wr_data         = rd_data | (32'd1 << zpos);
                    res_status_next = gbba_pkg::STS_OK;
                    res_block_next  = 13'(zgbit);
                    pend_next       = 1'b0;
                end
                else if (alloc_skip)
                begin
                    iss_next  = skip_iss;
                    pend_next = 1'b0;
                end
                else if (scan_end)
                begin
                    res_status_next = gbba_pkg::STS_NOSPACE;
                    res_block_next  = '0;
                end
                else if (can_issue)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = iss_reg[AW-1:0];
                    iss_next       = iss_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = iss_reg[AW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            gbba_pkg::S_FRD:
            begin
                rd_en   = 1'b1;
                rd_addr = f_wadr_reg;
            end
            gbba_pkg::S_FPROC:
            begin
                wr_en            = 1'b1;
                wr_addr          = f_wadr_reg;
                wr_data          = rd_data & ~f_clr;
                res_cleared_next = res_cleared_reg + 11'(f_stop - {1'b0, f_lo_reg});
                f_wadr_next      = f_wadr_reg + 1'b1;
                f_lo_next        = 5'd0;
                if (f_anybad)
                begin
                    res_status_next = f_meta[f_badpos] ? gbba_pkg::STS_META :
                                                         gbba_pkg::STS_FREE;
                end
            end
            gbba_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_block_next   = res_block_reg;
                    out_cleared_next = res_cleared_reg;
                end
            end
            default: ;
        endcase
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.result_block   = out_block_reg;
    assign rsp.blocks_cleared = out_cleared_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbba_pkg::S_CLR;
            clr_reg       <= '0;
            iss_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            iss_reg       <= iss_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg   <= pend_addr_next;
        f_wadr_reg      <= f_wadr_next;
        f_lo_reg        <= f_lo_next;
        f_lastw_reg     <= f_lastw_next;
        f_hilast_reg    <= f_hilast_next;
        res_status_reg  <= res_status_next;
        res_block_reg   <= res_block_next;
        res_cleared_reg <= res_cleared_next;
        out_status_reg  <= out_status_next;
        out_block_reg   <= out_block_next;
        out_cleared_reg <= out_cleared_next;
    end

`ifndef SYNTHESIS
    // a found free bit ends the scan
    a_scan_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gbba_pkg::S_SCAN && wr_en) |=> state_reg == gbba_pkg::S_DONE)
        else $error("scan did not finish after allocation write");

    // a block number is only reported with ok status
    a_block_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.result_block != 13'd0) |-> rsp.status == gbba_pkg::STS_OK)
        else $error("block number reported on failed request");

    // a free never clears more than one group
    a_cleared_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.blocks_cleared <= 11'(gbba_pkg::GROUP_BLOCKS))
        else $error("cleared count beyond group size");

    // an accepted item leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != gbba_pkg::S_IDLE)
        else $error("block stayed idle after accepting an item");
`endif

endmodule
`default_nettype wire
